>>> rtl/ensc_pkg.sv
// Shared constants, register codes, sideband type and shift helpers for the compensation unit.
`timescale 1ns / 1ps

package ensc_pkg;

  localparam int unsigned DivW = 64;

  localparam logic [63:0] TfOffsetP   = 64'd128000;
  localparam logic [63:0] RawPresBase = 64'd1048576;
  localparam logic [63:0] PresScale   = 64'd3125;
  localparam logic [31:0] TfOffsetH   = 32'd76800;
  localparam logic [31:0] HumOffsetY  = 32'd2097152;
  localparam logic [31:0] HumClampMax = 32'd419430400;
  localparam logic [31:0] HumRoundX   = 32'd16384;
  localparam logic [31:0] HumBiasY    = 32'd32768;
  localparam logic [31:0] HumRoundY   = 32'd8192;
  localparam logic [31:0] TempRound   = 32'd128;

  typedef enum logic [2:0] {
    RegTempCoeffs    = 3'd0,
    RegPresCoeffsLow = 3'd1,
    RegPresCoeffsMid = 3'd2,
    RegPresCoeffsHigh = 3'd3,
    RegHumCoeffsA    = 3'd4,
    RegHumCoeffsB    = 3'd5
  } reg_idx_e;

  // Values that ride alongside the divider.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] vv;
    logic [31:0] ss;
    logic        dz;
  } div_sb_t;

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage

>>> rtl/ensc_in_if.sv
// Input channel carrying one raw reading set.
`timescale 1ns / 1ps

interface ensc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

>>> rtl/ensc_out_if.sv
// Output channel carrying one compensated result.
`timescale 1ns / 1ps

interface ensc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic [16:0] humidity_q22_10;
  logic        pressure_divisor_zero;

  modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  pressure_divisor_zero, input ready);
  modport sink (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                pressure_divisor_zero, output ready);
endinterface

>>> rtl/ensc_div.sv
// Pipelined 64-bit signed restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module ensc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [63:0]          num_i,
  input  logic [63:0]          den_i,
  input  ensc_pkg::div_sb_t    sb_i,
  output logic                 valid_o,
  output logic [63:0]          quot_o,
  output ensc_pkg::div_sb_t    sb_o
);

  localparam int unsigned N = ensc_pkg::DivW;

  logic [N-1:0]      rem_q [0:N];
  logic [N-1:0]      nq_q  [0:N];
  logic [N-1:0]      md_q  [0:N];
  logic              neg_q [0:N];
  ensc_pkg::div_sb_t sb_q  [0:N];
  logic              v_q   [0:N];

  logic [N-1:0]      quot_q;
  ensc_pkg::div_sb_t osb_q;
  logic              ov_q;

  // Take magnitudes and remember the quotient sign.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      nq_q[0]  <= num_i[N-1] ? (N'(0) - num_i) : num_i;
      md_q[0]  <= den_i[N-1] ? (N'(0) - den_i) : den_i;
      neg_q[0] <= num_i[N-1] ^ den_i[N-1];
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N:0]   r;
    logic         ge;
    logic [N:0]   diff;

    assign r    = {rem_q[k], nq_q[k][N-1]};
    assign diff = r - {1'b0, md_q[k]};
    assign ge   = (r >= {1'b0, md_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[N-1:0] : r[N-1:0];
        nq_q[k+1]  <= {nq_q[k][N-2:0], ge};
        md_q[k+1]  <= md_q[k];
        neg_q[k+1] <= neg_q[k];
        sb_q[k+1]  <= sb_q[k];
      end
    end
  end

  // Apply the sign.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_i) begin
      ov_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= neg_q[N] ? (N'(0) - nq_q[N]) : nq_q[N];
      osb_q  <= sb_q[N];
    end
  end

  assign valid_o = ov_q;
  assign quot_o  = quot_q;
  assign sb_o    = osb_q;

endmodule

>>> rtl/env_sensor_compensation_unit.sv
// Top level of the temperature, pressure and humidity compensation pipeline.
// Usage:
//   sample_i carries one raw reading set (temperature, pressure, humidity) per item;
//   result_o carries the compensated temperature, pressure, humidity and the
//   zero-divisor flag. Both use valid/ready; an item moves when both are high.
//   The APB port writes and reads the six calibration registers at byte address 8*i
//   (64-bit data). Write them only while no item is in flight.
// Pipeline: 7 stages of temperature and pre-divide arithmetic, 66 stages in the
//   pipelined divider (sign, 64 quotient bits, sign fix) and 4 post-divide stages
//   ending in the output register.
// Throughput: one item per cycle while the result is not held; every stage holds its own item.
// Reset clears all valid bits and the calibration registers to zero.
// When the receiver stalls a held result, the whole pipeline freezes in place and
//   sample_i.ready drops; nothing is lost or repeated. While the output register is
//   empty or being drained, a new item is taken every cycle.
`timescale 1ns / 1ps

module env_sensor_compensation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ensc_in_if.sink     sample_i,
  ensc_out_if.source  result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [47:0] temp_coeffs_q, pres_low_q, pres_mid_q, pres_high_q;
  logic [39:0] hum_a_q;
  logic [31:0] hum_b_q;
  logic        apb_wr;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      pres_low_q    <= '0;
      pres_mid_q    <= '0;
      pres_high_q   <= '0;
      hum_a_q       <= '0;
      hum_b_q       <= '0;
    end else if (apb_wr) begin
      case (ensc_pkg::reg_idx_e'(paddr[5:3]))
        ensc_pkg::RegTempCoeffs:     temp_coeffs_q <= pwdata[47:0];
        ensc_pkg::RegPresCoeffsLow:  pres_low_q    <= pwdata[47:0];
        ensc_pkg::RegPresCoeffsMid:  pres_mid_q    <= pwdata[47:0];
        ensc_pkg::RegPresCoeffsHigh: pres_high_q   <= pwdata[47:0];
        ensc_pkg::RegHumCoeffsA:     hum_a_q       <= pwdata[39:0];
        ensc_pkg::RegHumCoeffsB:     hum_b_q       <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ensc_pkg::reg_idx_e'(paddr[5:3]))
      ensc_pkg::RegTempCoeffs:     prdata = {16'b0, temp_coeffs_q};
      ensc_pkg::RegPresCoeffsLow:  prdata = {16'b0, pres_low_q};
      ensc_pkg::RegPresCoeffsMid:  prdata = {16'b0, pres_mid_q};
      ensc_pkg::RegPresCoeffsHigh: prdata = {16'b0, pres_high_q};
      ensc_pkg::RegHumCoeffsA:     prdata = {24'b0, hum_a_q};
      ensc_pkg::RegHumCoeffsB:     prdata = {32'b0, hum_b_q};
      default:                     prdata = '0;
    endcase
  end

  // Unpack coefficients, extended to the datapath width they are used at.
  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'b0, temp_coeffs_q[15:0]};
  assign t2 = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
  assign t3 = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
  assign p1 = {48'b0, pres_low_q[15:0]};
  assign p2 = {{48{pres_low_q[31]}}, pres_low_q[31:16]};
  assign p3 = {{48{pres_low_q[47]}}, pres_low_q[47:32]};
  assign p4 = {{48{pres_mid_q[15]}}, pres_mid_q[15:0]};
  assign p5 = {{48{pres_mid_q[31]}}, pres_mid_q[31:16]};
  assign p6 = {{48{pres_mid_q[47]}}, pres_mid_q[47:32]};
  assign p7 = {{48{pres_high_q[15]}}, pres_high_q[15:0]};
  assign p8 = {{48{pres_high_q[31]}}, pres_high_q[31:16]};
  assign p9 = {{48{pres_high_q[47]}}, pres_high_q[47:32]};
  assign h1 = {24'b0, hum_a_q[7:0]};
  assign h2 = {{16{hum_a_q[23]}}, hum_a_q[23:8]};
  assign h3 = {24'b0, hum_a_q[31:24]};
  assign h6 = {{24{hum_a_q[39]}}, hum_a_q[39:32]};
  assign h4 = {{16{hum_b_q[15]}}, hum_b_q[15:0]};
  assign h5 = {{16{hum_b_q[31]}}, hum_b_q[31:16]};

  // ---------------------------------------------------------------------------
  // Pipeline control: advance every stage together unless the result is held.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_v_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, d1_v_q, d2_v_q, d3_v_q;
  logic div_v;

  assign en             = !out_v_q || result_o.ready;
  assign sample_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      d1_v_q  <= 1'b0;
      d2_v_q  <= 1'b0;
      d3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= sample_i.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      d1_v_q  <= div_v;
      d2_v_q  <= d1_v_q;
      d3_v_q  <= d2_v_q;
      out_v_q <= d3_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-3: temperature and fine temperature (32-bit wrap)
  // ---------------------------------------------------------------------------
  logic [31:0] at32, tx1, td;
  logic [31:0] s1_v1p_q, s1_dd_q;
  logic [19:0] s1_ap_q, s2_ap_q, s3_ap_q;
  logic [15:0] s1_ah_q, s2_ah_q, s3_ah_q, s4_ah_q;
  logic [31:0] s2_v1_q, s2_e_q, s3_tf_q;

  assign at32 = {12'b0, sample_i.raw_temperature};
  assign tx1  = (at32 >> 3) - (t1 << 1);
  assign td   = (at32 >> 4) - t1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v1p_q <= tx1 * t2;
      s1_dd_q  <= td * td;
      s1_ap_q  <= sample_i.raw_pressure;
      s1_ah_q  <= sample_i.raw_humidity;

      s2_v1_q  <= ensc_pkg::asr32(s1_v1p_q, 11);
      s2_e_q   <= ensc_pkg::asr32(s1_dd_q, 12) * t3;
      s2_ap_q  <= s1_ap_q;
      s2_ah_q  <= s1_ah_q;

      s3_tf_q  <= s2_v1_q + ensc_pkg::asr32(s2_e_q, 14);
      s3_ap_q  <= s2_ap_q;
      s3_ah_q  <= s2_ah_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4-7: pressure numerator/divisor and humidity front end
  // ---------------------------------------------------------------------------
  logic [63:0] pa;
  logic [31:0] hv;
  logic [31:0] s4_temp_q, s5_temp_q, s6_temp_q, s7_temp_q;
  logic [63:0] s4_aa_q, s4_ap5_q, s4_ap2_q, s4_nsub_q;
  logic [31:0] s4_m5_q, s4_m6_q, s4_m3_q;
  logic [63:0] s5_bb_q, s5_cc_q, s5_ap5_q, s5_ap2_q, s5_nsub_q;
  logic [31:0] s5_x_q, s5_y0_q;
  logic [63:0] s6_n0_q, s6_s_q;
  logic [31:0] s6_x_q, s6_y1_q;
  logic [63:0] s7_n_q, s7_sp_q;
  logic [31:0] s7_vv_q;
  logic [63:0] pb, pa2;
  logic [31:0] hy;

  assign pa = {{32{s3_tf_q[31]}}, s3_tf_q} - ensc_pkg::TfOffsetP;
  assign hv = s3_tf_q - ensc_pkg::TfOffsetH;
  assign pb  = s5_bb_q + (s5_ap5_q << 17) + (p4 << 35);
  assign pa2 = ensc_pkg::asr64(s5_cc_q, 8) + (s5_ap2_q << 12);
  assign hy  = ensc_pkg::asr32(s6_y1_q + ensc_pkg::HumRoundY, 14);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_temp_q <= ensc_pkg::asr32((s3_tf_q << 2) + s3_tf_q + ensc_pkg::TempRound, 8);
      s4_aa_q   <= pa * pa;
      s4_ap5_q  <= pa * p5;
      s4_ap2_q  <= pa * p2;
      s4_nsub_q <= ensc_pkg::RawPresBase - {44'b0, s3_ap_q};
      s4_m5_q   <= h5 * hv;
      s4_m6_q   <= hv * h6;
      s4_m3_q   <= hv * h3;
      s4_ah_q   <= s3_ah_q;

      s5_temp_q <= s4_temp_q;
      s5_bb_q   <= s4_aa_q * p6;
      s5_cc_q   <= s4_aa_q * p3;
      s5_ap5_q  <= s4_ap5_q;
      s5_ap2_q  <= s4_ap2_q;
      s5_nsub_q <= s4_nsub_q;
      s5_x_q    <= ensc_pkg::asr32(({16'b0, s4_ah_q} << 14) - (h4 << 20) - s4_m5_q
                                   + ensc_pkg::HumRoundX, 15);
      s5_y0_q   <= ensc_pkg::asr32(s4_m6_q, 10)
                   * (ensc_pkg::asr32(s4_m3_q, 11) + ensc_pkg::HumBiasY);

      s6_temp_q <= s5_temp_q;
      s6_n0_q   <= (s5_nsub_q << 31) - pb;
      s6_s_q    <= (64'd1 << 47) + pa2;
      s6_x_q    <= s5_x_q;
      s6_y1_q   <= (ensc_pkg::asr32(s5_y0_q, 10) + ensc_pkg::HumOffsetY) * h2;

      s7_temp_q <= s6_temp_q;
      s7_n_q    <= s6_n0_q * ensc_pkg::PresScale;
      s7_sp_q   <= s6_s_q * p1;
      s7_vv_q   <= s6_x_q * hy;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider; temperature and humidity partials ride along as sideband.
  // ---------------------------------------------------------------------------
  logic [63:0]       den;
  logic [31:0]       hs;
  ensc_pkg::div_sb_t div_sb_in, div_sb_out;
  logic [63:0]       div_q;

  assign den            = ensc_pkg::asr64(s7_sp_q, 33);
  assign hs             = ensc_pkg::asr32(s7_vv_q, 15);
  assign div_sb_in.temp = s7_temp_q;
  assign div_sb_in.vv   = s7_vv_q;
  assign div_sb_in.ss   = hs * hs;
  assign div_sb_in.dz   = (den == 64'd0);

  ensc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (s7_n_q),
    .den_i   (den),
    .sb_i    (div_sb_in),
    .valid_o (div_v),
    .quot_o  (div_q),
    .sb_o    (div_sb_out)
  );

  // ---------------------------------------------------------------------------
  // Post-divide: pressure correction terms and humidity finish
  // ---------------------------------------------------------------------------
  logic [63:0] q13;
  logic [63:0] d1_p_q, d1_q13_q, d1_pm_q, d1_c2m_q;
  logic [31:0] d1_w_q, d1_temp_q, d1_vv_q;
  logic        d1_dz_q;
  logic [63:0] d2_p_q, d2_ll_q, d2_c2_q;
  logic [31:0] d2_lh_q, d2_hl_q, d2_temp_q;
  logic [16:0] d2_hum_q;
  logic        d2_dz_q;
  logic [63:0] d3_p_q, d3_c1_q, d3_c2_q;
  logic [31:0] d3_temp_q;
  logic [16:0] d3_hum_q;
  logic        d3_dz_q;
  logic [31:0] hv2, hclamp;
  logic [31:0] pm_lo, pm_hi, q13_lo, q13_hi;
  logic [63:0] pfin;
  logic [31:0] out_temp_q, out_pres_q;
  logic [16:0] out_hum_q;
  logic        out_dz_q;

  assign q13    = ensc_pkg::asr64(div_q, 13);
  assign pm_lo  = d1_pm_q[31:0];
  assign pm_hi  = d1_pm_q[63:32];
  assign q13_lo = d1_q13_q[31:0];
  assign q13_hi = d1_q13_q[63:32];
  assign hv2    = d1_vv_q - ensc_pkg::asr32(d1_w_q, 4);

  // Clamp humidity: negative drops to zero, large values hold at the ceiling.
  always_comb begin
    if (hv2[31]) begin
      hclamp = '0;
    end else if (hv2 > ensc_pkg::HumClampMax) begin
      hclamp = ensc_pkg::HumClampMax;
    end else begin
      hclamp = hv2;
    end
  end

  assign pfin = ensc_pkg::asr64(d3_p_q + d3_c1_q + d3_c2_q, 8) + (p7 << 4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_p_q     <= div_q;
      d1_q13_q   <= q13;
      d1_pm_q    <= p9 * q13;
      d1_c2m_q   <= p8 * div_q;
      d1_w_q     <= ensc_pkg::asr32(div_sb_out.ss, 7) * h1;
      d1_temp_q  <= div_sb_out.temp;
      d1_vv_q    <= div_sb_out.vv;
      d1_dz_q    <= div_sb_out.dz;

      // Low 64 bits of the wide product from three 32x32 partial products.
      d2_p_q     <= d1_p_q;
      d2_ll_q    <= {32'b0, pm_lo} * {32'b0, q13_lo};
      d2_lh_q    <= pm_lo * q13_hi;
      d2_hl_q    <= pm_hi * q13_lo;
      d2_c2_q    <= ensc_pkg::asr64(d1_c2m_q, 19);
      d2_temp_q  <= d1_temp_q;
      d2_hum_q   <= hclamp[28:12];
      d2_dz_q    <= d1_dz_q;

      d3_p_q     <= d2_p_q;
      d3_c1_q    <= ensc_pkg::asr64(d2_ll_q + {d2_lh_q + d2_hl_q, 32'b0}, 25);
      d3_c2_q    <= d2_c2_q;
      d3_temp_q  <= d2_temp_q;
      d3_hum_q   <= d2_hum_q;
      d3_dz_q    <= d2_dz_q;

      out_temp_q <= d3_temp_q;
      out_pres_q <= d3_dz_q ? 32'd0 : pfin[31:0];
      out_hum_q  <= d3_hum_q;
      out_dz_q   <= d3_dz_q;
    end
  end

  assign result_o.valid                 = out_v_q;
  assign result_o.temperature_centi     = out_temp_q;
  assign result_o.pressure_q24_8        = out_pres_q;
  assign result_o.humidity_q22_10       = out_hum_q;
  assign result_o.pressure_divisor_zero = out_dz_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_dz_zero_pres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.pressure_divisor_zero) |-> (result_o.pressure_q24_8 == 32'd0))
    else $error("pressure not zero on zero divisor");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.humidity_q22_10 <= 17'd102400))
    else $error("humidity above clamp");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> v1_q)
    else $error("accepted item lost at first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> ($stable(v7_q) && $stable(d3_v_q)))
    else $error("pipeline moved during stall");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the sensor compensation unit: table-driven and random stimulus.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseItems = 165;

  // Calibration sets used by the directed table.
  typedef enum int {
    SetReset,
    SetTypical,
    SetAllOnes,
    SetNoDivisor
  } cal_set_e;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] pres;
    logic [16:0] hum;
    logic        dz;
  } comp_result_t;

  typedef struct {
    cal_set_e     cal;
    logic [19:0]  raw_t;
    logic [19:0]  raw_p;
    logic [15:0]  raw_h;
    bit           typed;
    comp_result_t want;
  } reading_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ensc_in_if  sample_if ();
  ensc_out_if result_if ();

  env_sensor_compensation_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .result_o (result_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Local copy of the calibration registers, masked to their widths.
  logic [47:0] cal_temp;
  logic [47:0] cal_pres_lo;
  logic [47:0] cal_pres_mid;
  logic [47:0] cal_pres_hi;
  logic [39:0] cal_hum_a;
  logic [31:0] cal_hum_b;

  comp_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  cycles;
  // Idle pattern: 0 receiver idles more, 1 sender idles more, 2 no idling.
  int unsigned  idle_mode;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: integer compensation at the block's datapath widths
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx8(logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sra32(logic [31:0] x, int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // Signed divide truncating toward zero; most negative / -1 wraps to itself.
  function automatic logic [63:0] div_trunc64(logic [63:0] n, logic [63:0] d);
    logic [63:0] mag_n;
    logic [63:0] mag_d;
    logic [63:0] quo;
    mag_n = n[63] ? 64'd0 - n : n;
    mag_d = d[63] ? 64'd0 - d : d;
    quo   = mag_n / mag_d;
    return (n[63] ^ d[63]) ? 64'd0 - quo : quo;
  endfunction

  function automatic comp_result_t compensate(logic [19:0] raw_t, logic [19:0] raw_p,
                                              logic [15:0] raw_h);
    comp_result_t res;
    logic [31:0] at, ah, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] v1, dt, v2, tfine, hv, hx, hy, hs;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] va, vb, vp, vq, c1, c2;
    at = {12'd0, raw_t};
    ah = {16'd0, raw_h};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = 32'(sx16(cal_temp[31:16]));
    t3 = 32'(sx16(cal_temp[47:32]));
    p1 = {48'd0, cal_pres_lo[15:0]};
    p2 = sx16(cal_pres_lo[31:16]);
    p3 = sx16(cal_pres_lo[47:32]);
    p4 = sx16(cal_pres_mid[15:0]);
    p5 = sx16(cal_pres_mid[31:16]);
    p6 = sx16(cal_pres_mid[47:32]);
    p7 = sx16(cal_pres_hi[15:0]);
    p8 = sx16(cal_pres_hi[31:16]);
    p9 = sx16(cal_pres_hi[47:32]);
    h1 = {24'd0, cal_hum_a[7:0]};
    h2 = 32'(sx16(cal_hum_a[23:8]));
    h3 = {24'd0, cal_hum_a[31:24]};
    h6 = 32'(sx8(cal_hum_a[39:32]));
    h4 = 32'(sx16(cal_hum_b[15:0]));
    h5 = 32'(sx16(cal_hum_b[31:16]));

    v1       = sra32(((at >> 3) - (t1 << 1)) * t2, 11);
    dt       = (at >> 4) - t1;
    v2       = sra32(sra32(dt * dt, 12) * t3, 14);
    tfine    = v1 + v2;
    res.temp = sra32(tfine * 32'd5 + ensc_pkg::TempRound, 8);

    va = {{32{tfine[31]}}, tfine} - ensc_pkg::TfOffsetP;
    vb = va * va * p6;
    vb = vb + ((va * p5) << 17);
    vb = vb + (p4 << 35);
    va = sra64(va * va * p3, 8) + ((va * p2) << 12);
    va = sra64(((64'd1 << 47) + va) * p1, 33);
    if (va == 64'd0) begin
      res.dz   = 1'b1;
      res.pres = 32'd0;
    end else begin
      res.dz   = 1'b0;
      vp       = ensc_pkg::RawPresBase - {44'd0, raw_p};
      vp       = div_trunc64(((vp << 31) - vb) * ensc_pkg::PresScale, va);
      vq       = sra64(vp, 13);
      c1       = sra64(p9 * vq * vq, 25);
      c2       = sra64(p8 * vp, 19);
      vp       = sra64(vp + c1 + c2, 8) + (p7 << 4);
      res.pres = vp[31:0];
    end

    hv = tfine - ensc_pkg::TfOffsetH;
    hx = sra32(((ah << 14) - (h4 << 20) - h5 * hv) + ensc_pkg::HumRoundX, 15);
    hy = sra32(hv * h6, 10) * (sra32(hv * h3, 11) + ensc_pkg::HumBiasY);
    hy = sra32((sra32(hy, 10) + ensc_pkg::HumOffsetY) * h2 + ensc_pkg::HumRoundY, 14);
    hv = hx * hy;
    hs = sra32(hv, 15);
    hv = hv - sra32(sra32(hs * hs, 7) * h1, 4);
    if (hv[31]) begin
      hv = 32'd0;
    end else if (hv > ensc_pkg::HumClampMax) begin
      hv = ensc_pkg::HumClampMax;
    end
    res.hum = hv[28:12];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic cal_write(int unsigned idx, logic [63:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 6'(idx * 8);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    // pready is tied high, so the access completes at this edge.
    case (idx)
      ensc_pkg::RegTempCoeffs:     cal_temp     = value[47:0];
      ensc_pkg::RegPresCoeffsLow:  cal_pres_lo  = value[47:0];
      ensc_pkg::RegPresCoeffsMid:  cal_pres_mid = value[47:0];
      ensc_pkg::RegPresCoeffsHigh: cal_pres_hi  = value[47:0];
      ensc_pkg::RegHumCoeffsA:     cal_hum_a    = value[39:0];
      ensc_pkg::RegHumCoeffsB:     cal_hum_b    = value[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Typical factory calibration, optionally jittered in the low byte of each field.
  task automatic load_typical(bit jitter);
    logic [15:0] f [18];
    f = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
          16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000,
          16'd75, 16'd362, 16'd0, 16'd30, 16'd313, 16'd50};
    if (jitter) begin
      foreach (f[i]) f[i] = f[i] ^ 16'($urandom_range(0, 255));
    end
    cal_write(ensc_pkg::RegTempCoeffs,     {16'($urandom), f[2], f[1], f[0]});
    cal_write(ensc_pkg::RegPresCoeffsLow,  {16'($urandom), f[5], f[4], f[3]});
    cal_write(ensc_pkg::RegPresCoeffsMid,  {16'($urandom), f[8], f[7], f[6]});
    cal_write(ensc_pkg::RegPresCoeffsHigh, {16'($urandom), f[11], f[10], f[9]});
    cal_write(ensc_pkg::RegHumCoeffsA,
              {24'($urandom), f[15][7:0], f[14][7:0], f[13], f[12][7:0]});
    cal_write(ensc_pkg::RegHumCoeffsB,     {32'($urandom), f[17], f[16]});
  endtask

  task automatic load_set(cal_set_e which);
    case (which)
      SetTypical: load_typical(1'b0);
      SetAllOnes: begin
        for (int unsigned i = 0; i < 6; i++) cal_write(i, '1);
      end
      SetNoDivisor: begin
        load_typical(1'b0);
        // Clear P1 so the pressure divisor is zero.
        cal_write(ensc_pkg::RegPresCoeffsLow, {16'd0, cal_pres_lo[47:16], 16'd0});
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_reading(logic [19:0] raw_t, logic [19:0] raw_p, logic [15:0] raw_h,
                              bit typed, comp_result_t want);
    @(negedge clk_i);
    // Idle the sender for a random stretch before offering the item.
    while ((idle_mode == 0 && $urandom_range(0, 99) < 37) ||
           (idle_mode == 1 && $urandom_range(0, 99) < 69)) begin
      sample_if.valid = 1'b0;
      @(negedge clk_i);
    end
    sample_if.valid           = 1'b1;
    sample_if.raw_temperature = raw_t;
    sample_if.raw_pressure    = raw_p;
    sample_if.raw_humidity    = raw_h;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    pending_results.push_back(typed ? want : compensate(raw_t, raw_p, raw_h));
  endtask

  // Hold off until every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    sample_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [19:0] pick20();
    case ($urandom_range(0, 7))
      0:       return 20'd0;
      1:       return '1;
      default: return 20'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure, in-order scoreboard
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (idle_mode == 0) begin
      result_if.ready <= ($urandom_range(0, 99) >= 69);
    end else if (idle_mode == 1) begin
      result_if.ready <= ($urandom_range(0, 99) >= 37);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    comp_result_t got;
    comp_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = '{result_if.temperature_centi, result_if.pressure_q24_8,
              result_if.humidity_q22_10, result_if.pressure_divisor_zero};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: temp %h pres %h hum %h dz %b",
                   got.temp, got.pres, got.hum, got.dz);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.temp != want.temp || got.pres != want.pres ||
            got.hum != want.hum || got.dz != want.dz) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: temp %h/%h pres %h/%h hum %h/%h dz %b/%b (exp/act)",
                     want.temp, got.temp, want.pres, got.pres,
                     want.hum, got.hum, want.dz, got.dz);
          end
        end
      end
    end
  end

  // Watchdog: end the run if the pipeline hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    reading_row_t rows[$];
    cal_set_e     cur_set;
    comp_result_t zero_cal;
    comp_result_t none;

    mismatches                = 0;
    cycles                    = 0;
    idle_mode                 = 0;
    rst_ni                    = 1'b0;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    sample_if.valid           = 1'b0;
    sample_if.raw_temperature = '0;
    sample_if.raw_pressure    = '0;
    sample_if.raw_humidity    = '0;
    result_if.ready           = 1'b0;
    cal_temp                  = '0;
    cal_pres_lo               = '0;
    cal_pres_mid              = '0;
    cal_pres_hi               = '0;
    cal_hum_a                 = '0;
    cal_hum_b                 = '0;
    // With all coefficients zero: temperature rounds to 0, the divisor is zero,
    // and humidity collapses to 0, whatever the raw readings.
    zero_cal = '{32'd0, 32'd0, 17'd0, 1'b1};
    none     = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: reset values, typical set, saturated set, zero divisor.
    rows = '{
      '{SetReset,     20'd0,      20'd0,      16'd0,      1'b1, zero_cal},
      '{SetReset,     20'hFFFFF,  20'hFFFFF,  16'hFFFF,   1'b1, zero_cal},
      '{SetReset,     20'h80000,  20'h7FFFF,  16'h8000,   1'b1, zero_cal},
      '{SetTypical,   20'd519888, 20'd415148, 16'd28000,  1'b0, none},
      '{SetTypical,   20'd0,      20'd0,      16'd0,      1'b0, none},
      '{SetTypical,   20'hFFFFF,  20'hFFFFF,  16'hFFFF,   1'b0, none},
      '{SetTypical,   20'd0,      20'hFFFFF,  16'hFFFF,   1'b0, none},
      '{SetTypical,   20'hFFFFF,  20'd0,      16'd0,      1'b0, none},
      '{SetTypical,   20'h55555,  20'hAAAAA,  16'h5555,   1'b0, none},
      '{SetTypical,   20'hAAAAA,  20'h55555,  16'hAAAA,   1'b0, none},
      '{SetTypical,   20'd500000, 20'd300000, 16'd40000,  1'b0, none},
      '{SetTypical,   20'd540000, 20'd450000, 16'd10000,  1'b0, none},
      '{SetAllOnes,   20'd0,      20'd0,      16'd0,      1'b0, none},
      '{SetAllOnes,   20'hFFFFF,  20'hFFFFF,  16'hFFFF,   1'b0, none},
      '{SetAllOnes,   20'h12345,  20'h6789A,  16'hBCDE,   1'b0, none},
      '{SetNoDivisor, 20'd519888, 20'd415148, 16'd28000,  1'b0, none},
      '{SetNoDivisor, 20'hFFFFF,  20'd0,      16'hFFFF,   1'b0, none}
    };
    cur_set = SetReset;
    foreach (rows[i]) begin
      if (rows[i].cal != cur_set) begin
        drain();
        load_set(rows[i].cal);
        cur_set = rows[i].cal;
      end
      send_reading(rows[i].raw_t, rows[i].raw_p, rows[i].raw_h, rows[i].typed, rows[i].want);
    end

    // Writes past the last register must be ignored.
    drain();
    cal_write(6, '1);
    cal_write(7, '1);
    send_reading(20'd519888, 20'd415148, 16'd28000, 1'b0, none);

    // Random phases: each drains, reloads calibration, then streams readings.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain();
      idle_mode = ph * 3 / NumPhases;
      if (ph % 3 == 2) begin
        for (int unsigned r = 0; r < 6; r++) cal_write(r, {$urandom, $urandom});
      end else begin
        load_typical(ph % 3 == 1);
      end
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_reading(pick20(), pick20(), 16'($urandom), 1'b0, none);
      end
    end

    drain();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
